>>> rtl/core/lwd_pkg.sv
`timescale 1ns / 1ps

package lwd_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int LEN_W     = 5;

  localparam logic [WIN_AW-1:0] WIN_START_RST = WIN_AW'(12'hfee);
  localparam logic [LEN_W-1:0]  LEN_BIAS      = LEN_W'(3);

  typedef logic [WIN_AW-1:0] win_addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_DATA = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_LIT   = 2'd1,
    TOK_MATCH = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    logic [7:0] lit;
    win_addr_t  offset;
    len_t       len;
  } tok_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_COPY  = 2'd2
  } state_t;

endpackage

>>> rtl/core/lzss_window_decoder_unit.sv
`timescale 1ns / 1ps

// LZSS decoder with a 4 KiB window held in one RAM. Flag bytes and the first
// byte of a match emit nothing; a literal emits one beat; a match emits its
// length in beats (3 to 18), one beat per cycle while the output is not
// stalled, bounded by the single window read port with forwarding of the byte
// just written. After reset and after every beat marked final_byte the window
// is zeroed by a pass over all 4096 addresses, during which no input is taken;
// window_start writes are taken at any time and apply from the next stream
// start.
module lzss_window_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);

  lwd_pkg::state_t    state, state_next;
  lwd_pkg::tok_t      tok;
  lwd_pkg::win_addr_t window_start, wp, rd_ptr, clr_addr;
  lwd_pkg::len_t      cnt;
  logic               fin_pend;
  logic               fwd;
  logic [7:0]         fwd_data, ram_rdata, eff;
  logic               can_push, take;
  logic               we, re;
  lwd_pkg::win_addr_t waddr, raddr;
  logic [7:0]         wdata;

  assign can_push = !out_valid || out_ready;
  assign in_ready = (state == lwd_pkg::ST_IDLE) && can_push;
  assign take     = in_valid && in_ready;
  assign eff      = fwd ? fwd_data : ram_rdata;

  lwd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .final_byte(final_byte),
    .tok       (tok)
  );

  lwd_ram #(
    .Width(8),
    .Depth(lwd_pkg::WIN_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = wp;
    wdata      = eff;
    re         = 1'b0;
    raddr      = rd_ptr;
    case (state)
      lwd_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = 8'd0;
        if (clr_addr == '1) begin
          state_next = lwd_pkg::ST_IDLE;
        end
      end
      lwd_pkg::ST_IDLE: begin
        if (take) begin
          if (tok.kind == lwd_pkg::TOK_LIT) begin
            we    = 1'b1;
            wdata = tok.lit;
          end
          if (tok.kind == lwd_pkg::TOK_MATCH) begin
            re         = 1'b1;
            raddr      = tok.offset;
            state_next = lwd_pkg::ST_COPY;
          end else if (final_byte) begin
            state_next = lwd_pkg::ST_CLEAR;
          end
        end
      end
      lwd_pkg::ST_COPY: begin
        if (can_push) begin
          we = 1'b1;
          re = 1'b1;
          if (cnt == lwd_pkg::len_t'(1)) begin
            state_next = fin_pend ? lwd_pkg::ST_CLEAR : lwd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = lwd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // read data forwarding: a read that hits the address written in the same
  // cycle sees the new byte
  always_ff @(posedge clk) begin
    if (re) begin
      fwd      <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= lwd_pkg::WIN_START_RST;
      wp           <= lwd_pkg::WIN_START_RST;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      fin_pend     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_start <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        lwd_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        lwd_pkg::ST_IDLE: begin
          if (take) begin
            if (tok.kind == lwd_pkg::TOK_LIT) begin
              out_valid   <= 1'b1;
              out_byte    <= tok.lit;
              last_of_run <= 1'b1;
              wp          <= wp + 1'b1;
            end
            if (tok.kind == lwd_pkg::TOK_MATCH) begin
              cnt      <= tok.len;
              rd_ptr   <= tok.offset + 1'b1;
              fin_pend <= final_byte;
            end else if (final_byte) begin
              wp       <= window_start;
              clr_addr <= '0;
            end
          end
        end
        lwd_pkg::ST_COPY: begin
          if (can_push) begin
            out_valid   <= 1'b1;
            out_byte    <= eff;
            last_of_run <= (cnt == lwd_pkg::len_t'(1));
            wp          <= wp + 1'b1;
            cnt         <= cnt - 1'b1;
            rd_ptr      <= rd_ptr + 1'b1;
            if (cnt == lwd_pkg::len_t'(1) && fin_pend) begin
              wp       <= window_start;
              clr_addr <= '0;
            end
          end
        end
        default: begin
          clr_addr <= '0;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/lwd_ram.sv
`timescale 1ns / 1ps

module lwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lwd_parser.sv
`timescale 1ns / 1ps

module lwd_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          final_byte,
  output lwd_pkg::tok_t tok
);

  lwd_pkg::phase_t phase, phase_next;
  logic [8:0]      ctrl, ctrl_next;
  logic [7:0]      match_low, match_low_next;

  always_comb begin
    tok.kind       = lwd_pkg::TOK_NONE;
    tok.lit        = in_byte;
    tok.offset     = {in_byte[7:4], match_low};
    tok.len        = lwd_pkg::len_t'(in_byte[3:0]) + lwd_pkg::LEN_BIAS;
    phase_next     = phase;
    ctrl_next      = ctrl;
    match_low_next = match_low;
    case (phase)
      lwd_pkg::PH_DATA: begin
        if (ctrl[8:1] != 8'd0) begin
          if (ctrl[0]) begin
            tok.kind   = lwd_pkg::TOK_LIT;
            ctrl_next  = {1'b0, ctrl[8:1]};
            phase_next = (ctrl[8:2] == 7'd0) ? lwd_pkg::PH_FLAG : lwd_pkg::PH_DATA;
          end else begin
            match_low_next = in_byte;
            phase_next     = lwd_pkg::PH_HIGH;
          end
        end else begin
          ctrl_next  = {1'b1, in_byte};
          phase_next = lwd_pkg::PH_DATA;
        end
      end
      lwd_pkg::PH_HIGH: begin
        tok.kind       = lwd_pkg::TOK_MATCH;
        match_low_next = 8'd0;
        ctrl_next      = {1'b0, ctrl[8:1]};
        phase_next     = (ctrl[8:2] == 7'd0) ? lwd_pkg::PH_FLAG : lwd_pkg::PH_DATA;
      end
      default: begin
        ctrl_next  = {1'b1, in_byte};
        phase_next = lwd_pkg::PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lwd_pkg::PH_FLAG;
      ctrl      <= 9'd0;
      match_low <= 8'd0;
    end else if (take) begin
      if (final_byte) begin
        phase     <= lwd_pkg::PH_FLAG;
        ctrl      <= 9'd0;
        match_low <= 8'd0;
      end else begin
        phase     <= phase_next;
        ctrl      <= ctrl_next;
        match_low <= match_low_next;
      end
    end
  end

endmodule
